### rtl/rmsl_pkg.sv
// ----------------------------------------------------------------------------
// rmsl_pkg: shared definitions for the frame RMS level meter
// Field widths, reset values and the small status types that pass between
// the front end, the frame queue and the back end.
// ----------------------------------------------------------------------------
package rmsl_pkg;

   // Payload widths fixed by the interface.
   localparam int SAMPLE_W         = 16;
   localparam int LEVEL_W          = 16;
   localparam int FRAME_LENGTH_W   = 13;

   // Reset value of the frame length register.
   localparam logic [FRAME_LENGTH_W-1:0] FRAME_LENGTH_RESET = 13'd960;

   // Default bound on the effective frame length.
   localparam int DEF_MAX_FRAME_LENGTH = 4096;

   // A squared 16-bit magnitude is at most 2**30, so it fits in 31 bits.
   localparam int SQ_W = 31;

   // Queue fill status seen by the front end and by the top level.
   typedef struct packed {
      logic full;
      logic empty;
   } rmsl_q_stat_type;

endpackage

### rtl/rmsl_if.sv
// ----------------------------------------------------------------------------
// rmsl_if: channel interfaces of the frame RMS level meter
// Valid/ready channels for audio samples, level results and the frame
// length register write port.
// ----------------------------------------------------------------------------

// Audio sample channel.
interface rmsl_sample_if;
   import rmsl_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] audio_sample;

   modport source (output valid, output audio_sample, input ready);
   modport sink   (input valid, input audio_sample, output ready);
endinterface

// Level result channel.
interface rmsl_level_if;
   import rmsl_pkg::*;
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] rms_level;

   modport source (output valid, output rms_level, input ready);
   modport sink   (input valid, input rms_level, output ready);
endinterface

// Frame length register write channel.
interface rmsl_csr_if;
   import rmsl_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [FRAME_LENGTH_W-1:0] frame_length;

   modport source (output valid, output frame_length, input ready);
   modport sink   (input valid, input frame_length, output ready);
endinterface

### rtl/rmsl_front.sv
// ----------------------------------------------------------------------------
// rmsl_front: sample intake and frame accumulation
// Holds the frame length register, takes one sample beat at a time, squares
// and accumulates it, and hands each finished frame sum with its length to
// the frame queue.
// ----------------------------------------------------------------------------
module rmsl_front #(
   parameter int MAX_FRAME_LENGTH = rmsl_pkg::DEF_MAX_FRAME_LENGTH,
   parameter int LEN_W            = 13,
   parameter int SUM_W            = 43
) (
   input  logic                     clock,
   input  logic                     reset,
   rmsl_sample_if.sink              req_bus,
   rmsl_csr_if.sink                 csr_bus,
   input  rmsl_pkg::rmsl_q_stat_type q_stat,
   output logic                     push_valid,
   output logic [SUM_W+LEN_W-1:0]   push_data
);
   import rmsl_pkg::*;

   logic [FRAME_LENGTH_W-1:0] frame_length_ff;
   logic                      pend_ff;
   logic [SAMPLE_W-1:0]       sample_ff;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [LEN_W-1:0]          cnt_ff, cnt_in;
   logic [LEN_W-1:0]          eff_len;
   logic [SAMPLE_W-1:0]       mag;
   logic [SQ_W-1:0]           square;
   logic                      frame_end;
   logic                      proceed;

   // Register writes are taken whenever the block is out of reset.
   assign csr_bus.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= FRAME_LENGTH_RESET;
      end else if (csr_bus.valid) begin
         frame_length_ff <= csr_bus.frame_length;
      end
   end

   // Effective length: zero acts as one, large values clamp to the bound.
   always_comb begin
      if (frame_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (32'(frame_length_ff) > 32'(MAX_FRAME_LENGTH)) begin
         eff_len = LEN_W'(MAX_FRAME_LENGTH);
      end else begin
         eff_len = LEN_W'(frame_length_ff);
      end
   end

   // One sample beat is held until it has been accumulated.
   assign req_bus.ready = !pend_ff && !reset;

   always_ff @(posedge clock) begin
      if (req_bus.valid && !pend_ff) begin
         sample_ff <= req_bus.audio_sample;
      end
   end

   // Magnitude, square and running sums of the held sample.
   assign mag       = sample_ff[SAMPLE_W-1] ? (~sample_ff + 1'b1) : sample_ff;
   assign square    = SQ_W'(mag) * SQ_W'(mag);
   assign sum_in    = sum_ff + SUM_W'(square);
   assign cnt_in    = cnt_ff + 1'b1;
   assign frame_end = (cnt_in >= eff_len);

   // A frame end waits for room in the queue.
   assign proceed    = pend_ff && (!frame_end || !q_stat.full);
   assign push_valid = pend_ff && frame_end;
   assign push_data  = {sum_in, eff_len};

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         sum_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         if (proceed) begin
            pend_ff <= 1'b0;
            sum_ff  <= frame_end ? '0 : sum_in;
            cnt_ff  <= frame_end ? '0 : cnt_in;
         end else if (req_bus.valid && !pend_ff) begin
            pend_ff <= 1'b1;
         end
      end
   end

endmodule

### rtl/rmsl_queue.sv
// ----------------------------------------------------------------------------
// rmsl_queue: two-entry frame queue
// Decouples the accumulating front end from the divide and root back end.
// ----------------------------------------------------------------------------
module rmsl_queue #(
   parameter int DATA_W = 56
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  logic [DATA_W-1:0]         push_data,
   input  logic                      pop,
   output logic [DATA_W-1:0]         head_data,
   output rmsl_pkg::rmsl_q_stat_type q_stat
);
   import rmsl_pkg::*;

   logic [DATA_W-1:0] entry_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        fill_ff;
   logic              do_push;
   logic              do_pop;

   assign q_stat.full  = (fill_ff == 2'd2);
   assign q_stat.empty = (fill_ff == 2'd0);
   assign do_push      = push_valid && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head_data    = entry_ff[rd_ptr_ff];

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fill_ff <= fill_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

endmodule

### rtl/rmsl_back.sv
// ----------------------------------------------------------------------------
// rmsl_back: per-frame divide and square root
// Takes one frame sum from the queue, divides it by the frame length one
// quotient bit per cycle, takes the floor square root one root bit per
// cycle and places the level in the result register.
// ----------------------------------------------------------------------------
module rmsl_back #(
   parameter int LEN_W = 13,
   parameter int SUM_W = 43
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [SUM_W+LEN_W-1:0] head_data,
   input  logic                   q_empty,
   output logic                   pop,
   rmsl_level_if.source           rsp_bus
);
   import rmsl_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_SQRT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   // A frame cut short by a lowered length can leave a mean far above 2**30,
   // so the root covers the whole sum width and the level is its low bits.
   localparam int ROOT_W     = (SUM_W + 1) / 2;
   localparam int ROOT_IN_W  = 2 * ROOT_W;
   localparam int SQRT_STEPS = ROOT_W;

   localparam int DIV_CNT_W  = $clog2(SUM_W);
   localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
   localparam int REM_W      = ROOT_W + 3;

   logic [1:0]            state_ff, state_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic [SQRT_CNT_W-1:0] sqrt_cnt_ff;
   logic [SUM_W-1:0]      quo_ff, quo_in;
   logic [LEN_W-1:0]      div_ff;
   logic [LEN_W-1:0]      drem_ff, drem_in;
   logic [LEN_W:0]        drem_shift;
   logic                  qbit;
   logic [ROOT_IN_W-1:0]  val_ff;
   logic [REM_W-1:0]      srem_ff, srem_in, srem_shift, trial;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic                  out_valid_ff;
   logic [LEVEL_W-1:0]    out_level_ff;
   logic                  out_load;

   // Restoring division step: shift in the next dividend bit.
   assign drem_shift = {drem_ff, quo_ff[SUM_W-1]};
   assign qbit       = (drem_shift >= {1'b0, div_ff});
   assign drem_in    = qbit ? LEN_W'(drem_shift - {1'b0, div_ff}) : drem_shift[LEN_W-1:0];
   assign quo_in     = {quo_ff[SUM_W-2:0], qbit};

   // Square root step: bring down two bits and try the next root bit.
   assign srem_shift = {srem_ff[REM_W-3:0], val_ff[ROOT_IN_W-1 -: 2]};
   assign trial      = {(REM_W-ROOT_W-2)'(0), root_ff, 2'b01};
   assign srem_in    = (srem_shift >= trial) ? (srem_shift - trial) : srem_shift;
   assign root_in    = {root_ff[ROOT_W-2:0], (srem_shift >= trial)};

   assign pop      = (state_ff == ST_IDLE) && !q_empty;
   assign out_load = (state_ff == ST_DONE) && (!out_valid_ff || rsp_bus.ready);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_cnt_ff == DIV_CNT_W'(SUM_W - 1)) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sqrt_cnt_ff == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers of the divide and root units.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            quo_ff     <= head_data[SUM_W+LEN_W-1:LEN_W];
            div_ff     <= head_data[LEN_W-1:0];
            drem_ff    <= '0;
            div_cnt_ff <= '0;
         end
         ST_DIV: begin
            quo_ff      <= quo_in;
            drem_ff     <= drem_in;
            div_cnt_ff  <= div_cnt_ff + 1'b1;
            val_ff      <= ROOT_IN_W'(quo_in);
            srem_ff     <= '0;
            root_ff     <= '0;
            sqrt_cnt_ff <= '0;
         end
         ST_SQRT: begin
            val_ff      <= {val_ff[ROOT_IN_W-3:0], 2'b00};
            srem_ff     <= srem_in;
            root_ff     <= root_in;
            sqrt_cnt_ff <= sqrt_cnt_ff + 1'b1;
         end
         ST_DONE: begin
            root_ff <= root_ff;
         end
         default: begin
            root_ff <= root_ff;
         end
      endcase
   end

   // Result register: a finished level waits here for its beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_level_ff <= root_ff[LEVEL_W-1:0];
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.rms_level = out_level_ff;

endmodule

### rtl/frame_rms_level_top.sv
// ----------------------------------------------------------------------------
// frame_rms_level_top: frame-based RMS level meter
// Accumulates squared audio samples over a frame and reports the floor
// square root of the floored mean square once per frame.
// ----------------------------------------------------------------------------
// Each sample beat is first registered and then squared and accumulated in
// the front end, and no new sample is accepted until the held one has been
// accumulated. A frame's last sample pushes the frame sum and its length
// into a two-entry queue; the back end then runs the bit-serial divide of
// the SUM_W-bit frame sum (SUM_W = 30 + clog2(MAX_FRAME_LENGTH + 1), 43 by
// default) and the bit-serial square root, whose root is (SUM_W + 1) / 2
// bits wide (22 by default), before the level appears on rsp_bus. This runs
// in parallel with the next frame's samples; intake only stalls if two frame
// sums are already waiting. A frame length of zero acts as one, values above
// MAX_FRAME_LENGTH act as that bound, and the length in force at a frame's
// last sample is the divisor. When a lowered length cuts a long frame short
// the root can exceed 16 bits, and the level is its low 16 bits.
// ----------------------------------------------------------------------------
module frame_rms_level_top #(
   parameter int MAX_FRAME_LENGTH = rmsl_pkg::DEF_MAX_FRAME_LENGTH
) (
   input  logic          clock,
   input  logic          reset,
   rmsl_sample_if.sink   req_bus,
   rmsl_level_if.source  rsp_bus,
   rmsl_csr_if.sink      csr_bus
);
   import rmsl_pkg::*;

   localparam int LEN_W = $clog2(MAX_FRAME_LENGTH + 1);
   localparam int SUM_W = SQ_W + LEN_W - 1;

   logic                   push_valid;
   logic [SUM_W+LEN_W-1:0] push_data;
   logic [SUM_W+LEN_W-1:0] head_data;
   logic                   pop;
   rmsl_q_stat_type        q_stat;

   // Sample intake and accumulation.
   rmsl_front #(
      .MAX_FRAME_LENGTH (MAX_FRAME_LENGTH),
      .LEN_W            (LEN_W),
      .SUM_W            (SUM_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .q_stat     (q_stat),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // Frame sums waiting for the back end.
   rmsl_queue #(
      .DATA_W (SUM_W + LEN_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head_data  (head_data),
      .q_stat     (q_stat)
   );

   // Divide, square root and result register.
   rmsl_back #(
      .LEN_W (LEN_W),
      .SUM_W (SUM_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_data (head_data),
      .q_empty   (q_stat.empty),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

   // The queue can never report full and empty together.
   a_q_stat_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("frame queue reports full and empty at once");

   // A frame sum pushed into a queue with room leaves it nonempty.
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (push_valid && !q_stat.full) |=> !q_stat.empty)
      else $error("pushed frame sum not visible in queue");

   // A level beat that is not taken stays offered with the same value.
   a_level_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=> (rsp_bus.valid && $stable(rsp_bus.rms_level)))
      else $error("waiting level beat changed or was dropped");

   // The back end only takes a frame sum that is present.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("back end popped an empty queue");

endmodule
